/* design/erc_pkg.sv */
// Shared constants, types and helper functions of the era threshold range collector.
`timescale 1ns / 1ps

package erc_pkg;

   // Default size of the block space and the largest block span that an index can address.
   localparam int NUM_BLOCKS_DEF = 65536;
   localparam int BLOCK_SPAN     = 65536;

   // Field widths.
   localparam int CMD_W  = 2;
   localparam int IDX_W  = 16;
   localparam int POS_W  = 17;
   localparam int ERA_W  = 32;
   localparam int WORD_W = 32;
   localparam int BIT_W  = 5;

   // Configuration port widths.
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_MARK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FETCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // Register index, taken from the word address of the configuration port.
   localparam logic REG_ERA_THRESHOLD = 1'b0;

   // One result beat.
   typedef struct packed {
      logic [IDX_W-1:0] range_begin;
      logic [POS_W-1:0] range_end;
      logic             single;
      logic             done_res;
   } res_type;

   // Position of the lowest set bit of a bitmap word.
   function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] bits);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (bits[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

/* design/erc_req_if.sv */
// Request channel interface of the era threshold range collector.
`timescale 1ns / 1ps

interface erc_req_if;
   logic                       valid;
   logic                       ready;
   logic [erc_pkg::CMD_W-1:0]  cmd;
   logic [erc_pkg::IDX_W-1:0]  block_index;
   logic [erc_pkg::ERA_W-1:0]  era;
   logic                       written;

   modport source (output valid, cmd, block_index, era, written, input ready);
   modport sink   (input valid, cmd, block_index, era, written, output ready);
endinterface

/* design/erc_rsp_if.sv */
// Response channel interface of the era threshold range collector.
`timescale 1ns / 1ps

interface erc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [erc_pkg::IDX_W-1:0]  range_begin;
   logic [erc_pkg::POS_W-1:0]  range_end;
   logic                       single;
   logic                       done_res;

   modport source (output valid, range_begin, range_end, single, done_res, input ready);
   modport sink   (input valid, range_begin, range_end, single, done_res, output ready);
endinterface

/* design/erc_csr.sv */
// APB-style configuration register holding the era threshold.
`timescale 1ns / 1ps

module erc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [erc_pkg::CSR_AW-1:0]  paddr,
   input  logic [erc_pkg::CSR_DW-1:0]  pwdata,
   output logic [erc_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output logic [erc_pkg::ERA_W-1:0]   era_threshold
);
   import erc_pkg::*;

   logic [ERA_W-1:0] threshold_ff;
   logic [ERA_W-1:0] threshold_in;
   logic             reg_hit;
   logic             wr_hit;

   // Decode the register from the word address.
   assign reg_hit = (paddr[CSR_AW-1] == REG_ERA_THRESHOLD);
   assign wr_hit  = psel & penable & pwrite & reg_hit;

   // The threshold takes the write data in the access phase.
   always_comb begin
      threshold_in = wr_hit ? pwdata : threshold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // Read back and a port that never waits.
   assign prdata        = reg_hit ? threshold_ff : '0;
   assign pready        = 1'b1;
   assign era_threshold = threshold_ff;

endmodule

/* design/erc_engine.sv */
// Bitmap memory and sequencer for marking, clearing and run fetching.
`timescale 1ns / 1ps

module erc_engine #(
   parameter int NUM_BLOCKS = erc_pkg::NUM_BLOCKS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   erc_req_if.sink                    req_chan,
   input  logic [erc_pkg::ERA_W-1:0]  era_threshold,
   input  logic                       out_free,
   output logic                       res_load,
   output erc_pkg::res_type           res
);
   import erc_pkg::*;

   // Geometry of the block space.
   localparam int LIMIT = (NUM_BLOCKS < BLOCK_SPAN) ? NUM_BLOCKS : BLOCK_SPAN;
   localparam int WORDS = (LIMIT + WORD_W - 1) / WORD_W;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int HI_W  = POS_W - BIT_W;
   localparam int TAIL  = LIMIT % WORD_W;

   localparam logic [POS_W-1:0]  LIMIT_POS = POS_W'(LIMIT);
   localparam logic [AW-1:0]     LAST_ADDR = AW'(WORDS - 1);
   localparam logic [HI_W-1:0]   LAST_HI   = HI_W'(WORDS - 1);
   localparam logic [WORD_W-1:0] ONES      = '1;
   localparam logic [WORD_W-1:0] LAST_MASK =
      (TAIL == 0) ? ONES : WORD_W'((64'd1 << TAIL) - 64'd1);

   // Sequencer states.
   localparam logic [2:0] ST_CLEAR     = 3'd0;
   localparam logic [2:0] ST_IDLE      = 3'd1;
   localparam logic [2:0] ST_MARK      = 3'd2;
   localparam logic [2:0] ST_SEEK      = 3'd3;
   localparam logic [2:0] ST_RUN_LOCAL = 3'd4;
   localparam logic [2:0] ST_RUN       = 3'd5;
   localparam logic [2:0] ST_EMIT      = 3'd6;

   logic [WORD_W-1:0] bitmap_ff [WORDS];
   logic [WORD_W-1:0] rd_data_ff;

   logic [2:0]        state_ff,    state_in;
   logic [POS_W-1:0]  cur_ff,      cur_in;
   logic [IDX_W-1:0]  begin_ff,    begin_in;
   logic [WORD_W-1:0] word_ff,     word_in;
   logic              mark_en_ff,  mark_en_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [POS_W-1:0]  scan_ff,     scan_in;
   logic [POS_W-1:0]  pend_end_ff, pend_end_in;
   logic              pend_done_ff, pend_done_in;

   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              wr_en;

   logic [HI_W-1:0]   cur_hi;
   logic [WORD_W-1:0] eff;
   logic [WORD_W-1:0] seek_bits;
   logic [WORD_W-1:0] local_zeros;
   logic [WORD_W-1:0] run_zeros;
   logic [WORD_W-1:0] bit_mask;
   logic [POS_W-1:0]  next_base;
   logic              past_end;

   // Bitmap memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= bitmap_ff[rd_addr];
   end

   // Word under the cursor, with bits beyond the block limit masked off.
   assign cur_hi      = cur_ff[POS_W-1:BIT_W];
   assign eff         = rd_data_ff & ((cur_hi == LAST_HI) ? LAST_MASK : ONES);
   assign seek_bits   = eff & (ONES << cur_ff[BIT_W-1:0]);
   assign local_zeros = ~word_ff & ((ONES << begin_ff[BIT_W-1:0]) << 1);
   assign run_zeros   = ~eff;
   assign bit_mask    = WORD_W'(1) << cur_ff[BIT_W-1:0];
   assign next_base   = {cur_hi, {BIT_W{1'b0}}} + POS_W'(WORD_W);
   assign past_end    = (next_base >= LIMIT_POS);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      begin_in     = begin_ff;
      word_in      = word_ff;
      mark_en_in   = mark_en_ff;
      clr_addr_in  = clr_addr_ff;
      scan_in      = scan_ff;
      pend_end_in  = pend_end_ff;
      pend_done_in = pend_done_ff;
      rd_addr      = scan_ff[BIT_W +: AW];
      wr_en        = 1'b0;
      wr_addr      = cur_ff[BIT_W +: AW];
      wr_data      = rd_data_ff | bit_mask;
      res_load     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               case (req_chan.cmd)
                  CMD_MARK: begin
                     rd_addr    = req_chan.block_index[BIT_W +: AW];
                     cur_in     = {1'b0, req_chan.block_index};
                     mark_en_in = req_chan.written && (req_chan.era >= era_threshold) &&
                                  ({1'b0, req_chan.block_index} < LIMIT_POS);
                     state_in   = ST_MARK;
                  end
                  CMD_FETCH: begin
                     cur_in = scan_ff;
                     if (scan_ff >= LIMIT_POS) begin
                        pend_done_in = 1'b1;
                        state_in     = ST_EMIT;
                     end else begin
                        pend_done_in = 1'b0;
                        state_in     = ST_SEEK;
                     end
                  end
                  CMD_CLEAR: begin
                     scan_in     = '0;
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MARK: begin
            wr_en    = mark_en_ff;
            state_in = ST_IDLE;
         end
         ST_SEEK: begin
            // Look for the first set bit at or after the cursor.
            if (|seek_bits) begin
               begin_in = IDX_W'({cur_hi, lowest_set(seek_bits)});
               word_in  = eff;
               state_in = ST_RUN_LOCAL;
            end else if (past_end) begin
               pend_done_in = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               cur_in  = next_base;
               rd_addr = next_base[BIT_W +: AW];
            end
         end
         ST_RUN_LOCAL: begin
            // Extend the run within the word where it begins.
            if (|local_zeros) begin
               pend_end_in = {cur_hi, lowest_set(local_zeros)};
               state_in    = ST_EMIT;
            end else if (past_end) begin
               pend_end_in = next_base;
               state_in    = ST_EMIT;
            end else begin
               cur_in   = next_base;
               rd_addr  = next_base[BIT_W +: AW];
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // Extend the run through following words until a clear bit.
            if (|run_zeros) begin
               pend_end_in = {cur_hi, lowest_set(run_zeros)};
               state_in    = ST_EMIT;
            end else if (past_end) begin
               pend_end_in = next_base;
               state_in    = ST_EMIT;
            end else begin
               cur_in  = next_base;
               rd_addr = next_base[BIT_W +: AW];
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               res_load = 1'b1;
               scan_in  = pend_done_ff ? LIMIT_POS : pend_end_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         scan_ff      <= '0;
         mark_en_ff   <= 1'b0;
         pend_done_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         scan_ff      <= scan_in;
         mark_en_ff   <= mark_en_in;
         pend_done_ff <= pend_done_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      begin_ff    <= begin_in;
      word_ff     <= word_in;
      pend_end_ff <= pend_end_in;
   end

   // Handshake and result beat.
   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      res.done_res    = pend_done_ff;
      res.range_begin = pend_done_ff ? '0 : begin_ff;
      res.range_end   = pend_done_ff ? '0 : pend_end_ff;
      res.single      = !pend_done_ff && (pend_end_ff == ({1'b0, begin_ff} + POS_W'(1)));
   end

   // Reset starts the clearing pass with the scan rewound.
   assert property (@(posedge clock) reset |=> (state_ff == ST_CLEAR) && (scan_ff == '0))
      else $error("reset did not start the clearing pass");

   // The scan position never runs past the block limit.
   assert property (@(posedge clock) disable iff (reset) scan_ff <= LIMIT_POS)
      else $error("scan position beyond block limit");

   // A result is only loaded when the output stage can take it.
   assert property (@(posedge clock) disable iff (reset) res_load |-> out_free)
      else $error("result loaded into a full output stage");

   // A mark write changes at most one bit of the word it read.
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && (state_ff == ST_MARK)) |-> ($countones(wr_data ^ rd_data_ff) <= 1))
      else $error("mark write changed more than one bit");

endmodule

/* design/erc_out_stage.sv */
// Output register that holds one result beat until the receiver takes it.
`timescale 1ns / 1ps

module erc_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              res_load,
   input  erc_pkg::res_type  res,
   output logic              out_free,
   erc_rsp_if.source         rsp_chan
);
   import erc_pkg::*;

   logic    valid_ff, valid_in;
   res_type data_ff,  data_in;

   // The stage can be loaded when empty or when its beat leaves this cycle.
   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff && !rsp_chan.ready;
      data_in  = data_ff;
      if (res_load) begin
         valid_in = 1'b1;
         data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.range_begin = data_ff.range_begin;
   assign rsp_chan.range_end   = data_ff.range_end;
   assign rsp_chan.single      = data_ff.single;
   assign rsp_chan.done_res    = data_ff.done_res;

endmodule

/* design/era_threshold_range_collector_unit.sv */
// Top level of the era threshold range collector.
`timescale 1ns / 1ps

// Collects blocks written since a threshold era in a bitmap and hands them out as runs.
// req_chan takes one command beat at a time: mark, fetch next run, or clear and rewind.
// rsp_chan carries one beat per fetch: begin, exclusive end and single flag, or done.
// The APB-style port holds the era threshold at byte address 0.
// A mark is a read of its bitmap word and the write back.
// A fetch that finds a run passes through acceptance, the read of the word at the scan
// position, the extension of the run within that word and the hand-over to the output
// register. Each further bitmap word that the search for the next set bit or the extension
// of the run passes through is read in turn through the single memory read port, one word
// per cycle. A fetch that finds no run searches up to the block limit and hands over a done
// beat, with no search when the scan already stands at the block limit.
// A clear rewinds the scan and runs a clearing pass over every bitmap word (2048 words
// with the default block count).
// After reset the same clearing pass runs before the first command is accepted; the
// threshold and the scan position reset to zero.
// A finished result waits in an output register, so the next command is accepted while
// the receiver stalls; a fetch that completes behind a held result waits for it to leave.
module era_threshold_range_collector_unit #(
   parameter int NUM_BLOCKS = erc_pkg::NUM_BLOCKS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   erc_req_if.sink                     req_chan,
   erc_rsp_if.source                   rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [erc_pkg::CSR_AW-1:0]  paddr,
   input  logic [erc_pkg::CSR_DW-1:0]  pwdata,
   output logic [erc_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);
   import erc_pkg::*;

   logic [ERA_W-1:0] era_threshold;
   res_type          res;
   logic             res_load;
   logic             out_free;

   // Configuration register.
   erc_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .era_threshold (era_threshold)
   );

   // Bitmap memory and command sequencer.
   erc_engine #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .era_threshold (era_threshold),
      .out_free      (out_free),
      .res_load      (res_load),
      .res           (res)
   );

   // Result register towards the receiver.
   erc_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .res_load (res_load),
      .res      (res),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule
